// File: rtl/gsm_pkg.sv
// ============================================================================
// gsm_pkg: shared types and constants of the glob segment matcher
// Command codes, the wildcard byte values and the structs that pass
// between the top level and the row of pattern cells.
// ============================================================================
package gsm_pkg;

    // Command carried in tuser with each input transaction.
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_NAME   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    localparam logic [7:0] QMARK_CODE = 8'h3F;
    localparam logic [7:0] STAR_CODE  = 8'h2A;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       take;   // a transaction is accepted this cycle
        logic       clr;    // the pattern is being cleared
        logic [7:0] code;   // pattern or name byte
    } cell_cmd_t;

    // Returned by each cell.
    typedef struct packed {
        logic step;         // this position matched the name byte
        logic raw_next;     // next active bit of this position before closure
        logic star_nxt;     // position holds a star after this transaction
    } cell_stat_t;

endpackage

// File: rtl/glob_segment_matcher_core.sv
// ============================================================================
// glob_segment_matcher_core: streaming glob matcher with '?' and '*'
// Stores a pattern in a row of cells and tracks the set of pattern
// positions reachable by the name bytes streamed so far.
// ============================================================================
// Usage:
// The input stream carries one command per transaction in s_tuser: clear
// the pattern, append a pattern byte, feed a name byte, or end the name.
// s_tdata carries the byte for append and name transactions.
// Only an end-of-name transaction produces an output transaction; its
// m_tdata reports whether the whole name matched the whole pattern and
// whether more than PATTERN_MAX pattern bytes were offered since the last
// clear (an overflowed pattern never matches).
// Every command is completed in the cycle it is accepted, so one transaction
// per cycle is sustained while s_tready is high. The result appears on
// m_tvalid in the cycle after the end-of-name transaction is accepted.
// The rate is set by the cell row: each name byte is compared in every
// cell at once and the star closure is one carry chain across all positions.
// The result sits in an output register; s_tready stays high while that
// register is empty or being read, so the input stalls only when a result
// is held by a stalled receiver.
// Reset clears the pattern, the overflow flag and the output register and
// leaves only the first position active. No clearing pass is needed.
// ============================================================================
module glob_segment_matcher_core #(
    parameter int PATTERN_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] func
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);
    import gsm_pkg::*;

    localparam int POS_N = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    func_t            func;
    logic             take;
    cell_cmd_t        cmd;
    cell_stat_t       stat [PATTERN_MAX];

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [POS_N-1:0] active_reg;

    logic [POS_N-1:0] raw_set;
    logic [POS_N-2:0] star_nxt;
    logic [POS_N-1:0] set_sel;
    logic [POS_N-1:0] closed;
    logic             at_capacity;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic             matched_reg;
    logic             overflow_reg;

    assign func     = func_t'(s_tuser);
    // The output register is free when empty or drained this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    assign cmd.take = take;
    assign cmd.clr  = (func == FUNC_CLEAR);
    assign cmd.code = s_tdata;

    assign at_capacity = (len_reg == LEN_W'(PATTERN_MAX));

    // Row of cells. Each cell hands its match to its right-hand neighbor.
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic step_in;
        logic wr_en;

        if (i == 0) begin : g_first
            assign step_in = 1'b0;
        end else begin : g_rest
            assign step_in = stat[i-1].step;
        end

        assign wr_en = (func == FUNC_APPEND) && (len_reg == LEN_W'(i));

        gsm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .wr_en    (wr_en),
            .active_i (active_reg[i]),
            .step_in  (step_in),
            .stat     (stat[i])
        );

        assign raw_set[i]  = stat[i].raw_next;
        assign star_nxt[i] = stat[i].star_nxt;
    end

    // The end-of-pattern position is reached only by a match in the last cell.
    assign raw_set[POS_N-1] = stat[PATTERN_MAX-1].step;

    // A name byte advances the set; every other command restarts it from
    // the first position, closed over the pattern as it stands afterwards.
    assign set_sel = (func == FUNC_NAME) ? raw_set : POS_N'(1);

    gsm_closure #(
        .POS_N (POS_N)
    ) u_closure (
        .set_i    (set_sel),
        .star_i   (star_nxt),
        .closed_o (closed)
    );

    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        case (func)
            FUNC_CLEAR: begin
                len_next = '0;
                ovf_next = 1'b0;
            end
            FUNC_APPEND: begin
                if (at_capacity) begin
                    ovf_next = 1'b1;
                end else begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            active_reg <= POS_N'(1);
        end else if (take) begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            active_reg <= closed;
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (take && (func == FUNC_END)) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && (func == FUNC_END)) begin
            matched_reg  <= active_reg[len_reg] && !ovf_reg;
            overflow_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, overflow_reg, matched_reg};

endmodule

// File: rtl/gsm_cell.sv
// ============================================================================
// gsm_cell: one pattern position of the glob segment matcher
// Holds one pattern byte and its valid bit, matches it against the name
// byte and hands the match on to the next position.
// ============================================================================
module gsm_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gsm_pkg::cell_cmd_t    cmd,
    input  logic                  wr_en,
    input  logic                  active_i,
    input  logic                  step_in,
    output gsm_pkg::cell_stat_t   stat
);
    import gsm_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       star_reg;
    logic       is_star;
    logic       hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.take && cmd.clr) begin
            valid_reg <= 1'b0;
        end else if (cmd.take && wr_en) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && wr_en) begin
            byte_reg <= cmd.code;
            star_reg <= (cmd.code == STAR_CODE);
        end
    end

    always_comb begin
        is_star = valid_reg && star_reg;
        // A non-star byte matches a question mark or the identical name byte.
        hit = valid_reg && !star_reg
              && ((byte_reg == QMARK_CODE) || (byte_reg == cmd.code));
        stat.step     = active_i && hit;
        stat.raw_next = (active_i && is_star) || step_in;
        if (cmd.clr) begin
            stat.star_nxt = 1'b0;
        end else if (wr_en) begin
            stat.star_nxt = (cmd.code == STAR_CODE);
        end else begin
            stat.star_nxt = is_star;
        end
    end

endmodule

// File: rtl/gsm_closure.sv
// ============================================================================
// gsm_closure: star closure of the active position set
// Each active star position also activates the next one; runs of stars
// propagate like a carry, so the closure is formed with one wide add.
// ============================================================================
module gsm_closure #(
    parameter int POS_N = 33
) (
    input  logic [POS_N-1:0] set_i,
    input  logic [POS_N-2:0] star_i,
    output logic [POS_N-1:0] closed_o
);
    logic [POS_N:0] a_ext;
    logic [POS_N:0] b_ext;
    logic [POS_N:0] sum;
    logic [POS_N:0] carry;

    // Propagate is a star, generate is an active star.
    always_comb begin
        a_ext    = {2'b00, star_i};
        b_ext    = a_ext & {1'b0, set_i};
        sum      = a_ext + b_ext;
        carry    = sum ^ a_ext ^ b_ext;
        closed_o = set_i | carry[POS_N-1:0];
    end

endmodule

// File: rtl/gsm_checker.sv
// ============================================================================
// gsm_checker: port-level checks for the glob segment matcher
// Watches the stream ports of the top level over time.
// ============================================================================
module gsm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import gsm_pkg::*;

    logic end_take;
    assign end_take = s_tvalid && s_tready && (s_tuser == FUNC_END);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every end-of-name transaction yields a result in the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        end_take |=> m_tvalid)
        else $error("end of name gave no result");

    // No result appears without an end-of-name transaction.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !end_take && !(m_tvalid && !m_tready) |=> !m_tvalid)
        else $error("result without end of name");

    // An overflowed pattern never reports a match.
    a_ovf_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported on overflowed pattern");

endmodule

bind glob_segment_matcher_core gsm_checker u_gsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/glob_segment_matcher_core_tb.sv
// ============================================================================
// glob_segment_matcher_core_tb: self-checking bench for the glob matcher
// Streams clear, append, name-byte and end-of-name transactions into the
// core. A behavioral copy of the position-set matcher predicts the verdict
// of every end of name. The bench starts with directed corner cases, then
// checks pattern overflow and output back-pressure. It ends with random
// pattern/name sequences under three idle profiles on both stream sides.
// ============================================================================
`timescale 1ns / 1ps

module glob_segment_matcher_core_tb;

    import gsm_pkg::*;

    localparam int PATTERN_MAX = 32;
    // Cycles with no transaction on either side before the run is declared
    // hung. The long receiver hold-off below stays under this.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [7:0] CHAR_A = 8'h61;

    // Verdict carried by one result transaction.
    typedef struct {
        logic matched;
        logic overflow;
    } verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] char_code
    logic [1:0] s_tuser = 2'd0;    // [1:0] func
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] matched, [1] overflow, [7:2] zero

    glob_segment_matcher_core #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Matcher prediction. The pattern copy and the set of live positions are
    // updated at the clock edge where each input transaction is accepted, so
    // they always mirror what the core has consumed.
    // ------------------------------------------------------------------------
    logic [7:0]       pat_mem [PATTERN_MAX];
    int unsigned      pat_len = 0;
    logic [PATTERN_MAX:0] live_pos;
    bit               pat_ovf = 1'b0;
    verdict_t         pending_verdicts [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  hold_off_left = 0;

    // An active star also activates the position after it. Walking upward
    // lets a run of stars propagate in one pass.
    function automatic logic [PATTERN_MAX:0] star_closure(logic [PATTERN_MAX:0] set);
        for (int i = 0; i < int'(pat_len); i++) begin
            if (set[i] && pat_mem[i] == STAR_CODE) begin
                set[i+1] = 1'b1;
            end
        end
        return set;
    endfunction

    function automatic logic [PATTERN_MAX:0] restarted_positions();
        logic [PATTERN_MAX:0] set;
        set = '0;
        set[0] = 1'b1;
        return star_closure(set);
    endfunction

    task automatic track_transaction(func_t func, logic [7:0] code);
        logic [PATTERN_MAX:0] nxt;
        verdict_t             v;
        case (func)
            FUNC_CLEAR: begin
                pat_len  = 0;
                pat_ovf  = 1'b0;
                live_pos = restarted_positions();
            end
            FUNC_APPEND: begin
                // A byte past capacity is dropped and latches the overflow flag.
                if (pat_len < PATTERN_MAX) begin
                    pat_mem[pat_len] = code;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                live_pos = restarted_positions();
            end
            FUNC_NAME: begin
                // A star holds its own position; a question mark or an equal
                // byte moves on by one. A star in the name is a plain byte.
                nxt = '0;
                for (int i = 0; i < int'(pat_len); i++) begin
                    if (live_pos[i]) begin
                        if (pat_mem[i] == STAR_CODE) begin
                            nxt[i] = 1'b1;
                        end else if (pat_mem[i] == QMARK_CODE || pat_mem[i] == code) begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                live_pos = star_closure(nxt);
            end
            default: begin
                v.matched  = live_pos[pat_len] && !pat_ovf;
                v.overflow = pat_ovf;
                pending_verdicts.insert(pending_verdicts.size(), v);
                live_pos = restarted_positions();
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side. Each call offers one transaction, changing the inputs only
    // at falling edges, and returns at the rising edge where it is accepted.
    // s_tvalid stays high on return so back-to-back calls give a gapless
    // stream; the idle loop lowers it when the sender is meant to pause.
    // ------------------------------------------------------------------------
    task automatic send_item(func_t func, logic [7:0] code);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
        track_transaction(func, code);
    endtask

    // Pattern bytes lean toward a small alphabet and the two wildcards so
    // that random names actually hit; a share of full-range bytes remains.
    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(9))
            0, 1, 2: return CHAR_A + 8'($urandom_range(1));
            3, 4:    return STAR_CODE;
            5, 6:    return QMARK_CODE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_name_byte();
        case ($urandom_range(5))
            0:       return STAR_CODE;
            1:       return QMARK_CODE;
            2, 3:    return CHAR_A + 8'($urandom_range(2));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Builds a name that fits the current pattern, optionally damaged by one
    // replaced, dropped or inserted byte, streams it and ends it.
    task automatic send_name(bit damage);
        logic [7:0] name_q [$];
        int         pos;
        for (int i = 0; i < int'(pat_len); i++) begin
            if (pat_mem[i] == STAR_CODE) begin
                repeat ($urandom_range(3)) name_q.insert(name_q.size(), pick_name_byte());
            end else if (pat_mem[i] == QMARK_CODE) begin
                name_q.insert(name_q.size(), 8'($urandom_range(255)));
            end else begin
                name_q.insert(name_q.size(), pat_mem[i]);
            end
        end
        if (damage) begin
            pos = (name_q.size() == 0) ? 0 : $urandom_range(name_q.size() - 1);
            case ($urandom_range(2))
                0: begin
                    if (name_q.size() > 0) name_q[pos] = pick_name_byte();
                end
                1: begin
                    if (name_q.size() > 0) name_q.delete(pos);
                end
                default: name_q.insert(pos, pick_name_byte());
            endcase
        end
        foreach (name_q[i]) begin
            send_item(FUNC_NAME, name_q[i]);
        end
        send_item(FUNC_END, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // Output side. m_tready follows the current idle percentage, except while
    // a hold-off is running, during which it stays low for a counted stretch.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic report_mismatch(string what);
        $display("ERROR at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Every accepted result is compared with the oldest pending verdict.
    always @(posedge aclk) begin : result_check
        verdict_t v;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result, m_tdata=%02h", m_tdata));
            end else begin
                v = pending_verdicts.pop_front();
                if (m_tdata[0] !== v.matched) begin
                    report_mismatch($sformatf("matched is %b, predicted %b",
                                              m_tdata[0], v.matched));
                end
                if (m_tdata[1] !== v.overflow) begin
                    report_mismatch($sformatf("overflow is %b, predicted %b",
                                              m_tdata[1], v.overflow));
                end
                if (m_tdata[7:2] !== 6'd0) begin
                    report_mismatch($sformatf("padding bits are %b, not zero",
                                              m_tdata[7:2]));
                end
            end
        end
    end

    // Ends the run if neither stream moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL glob_segment_matcher_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Empty names and patterns, star-only patterns, both wildcards against a
    // name star, extreme byte values and an append in the middle of a name.
    task automatic test_corner_cases();
        send_item(FUNC_CLEAR, 8'h00);
        send_item(FUNC_END, 8'hFF);           // empty pattern, empty name
        send_item(FUNC_NAME, CHAR_A);
        send_item(FUNC_END, 8'h00);           // empty pattern, one name byte
        send_item(FUNC_APPEND, STAR_CODE);
        send_item(FUNC_APPEND, STAR_CODE);
        send_item(FUNC_END, 8'h00);           // stars only, empty name
        send_item(FUNC_NAME, STAR_CODE);
        send_item(FUNC_NAME, 8'hFF);
        send_item(FUNC_END, 8'h00);           // stars swallow any bytes
        send_item(FUNC_CLEAR, 8'hFF);
        send_item(FUNC_APPEND, QMARK_CODE);
        send_item(FUNC_APPEND, 8'h00);
        send_item(FUNC_APPEND, 8'hFF);
        send_item(FUNC_NAME, STAR_CODE);      // question mark takes a name star
        send_item(FUNC_NAME, 8'h00);
        send_item(FUNC_NAME, 8'hFF);
        send_item(FUNC_END, 8'h00);
        send_item(FUNC_NAME, 8'h00);
        send_item(FUNC_APPEND, STAR_CODE);    // restarts the name in progress
        send_item(FUNC_NAME, 8'h00);
        send_item(FUNC_NAME, 8'h00);
        send_item(FUNC_NAME, 8'hFF);
        send_item(FUNC_END, 8'h00);
        send_item(FUNC_CLEAR, 8'h00);
        send_item(FUNC_APPEND, CHAR_A);
        send_item(FUNC_NAME, STAR_CODE);      // a name star is only a byte
        send_item(FUNC_END, 8'h00);
    endtask

    // Fills the pattern to capacity, then offers one byte too many: a fitting
    // name still reads as no match until a clear drops the flag.
    task automatic test_pattern_overflow();
        send_item(FUNC_CLEAR, 8'h00);
        repeat (PATTERN_MAX) send_item(FUNC_APPEND, pick_pattern_byte());
        send_name(1'b0);
        send_item(FUNC_APPEND, 8'($urandom_range(255)));
        send_name(1'b0);
        send_item(FUNC_APPEND, STAR_CODE);
        send_name(1'b0);
        send_item(FUNC_CLEAR, 8'h00);
        send_item(FUNC_END, 8'h00);
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // names, so the output register fills and s_tready has to drop.
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_item(FUNC_CLEAR, 8'h00);
        // Set right at the accept edge; the receiver picks it up at the next
        // falling edge without leaving the stream idle.
        hold_off_left = HOLD_OFF_CYCLES;
        send_item(FUNC_APPEND, CHAR_A);
        send_item(FUNC_APPEND, STAR_CODE);
        repeat (12) send_name($urandom_range(1));
    endtask

    // Mostly well-formed sequences: an optional clear, a short pattern (now
    // and then one long enough to overflow), then a few fitting or damaged
    // names. The rest is noise of arbitrary commands and bytes.
    task automatic test_random_traffic(int src_pct, int snk_pct, int n_items);
        int stop_at;
        int plen;
        stop_at = items_sent + n_items;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(func_t'(2'($urandom_range(3))), 8'($urandom_range(255)));
                end
            end else begin
                if ($urandom_range(3) != 0) begin
                    send_item(FUNC_CLEAR, 8'($urandom_range(255)));
                end
                if ($urandom_range(15) == 0) begin
                    plen = $urandom_range(PATTERN_MAX - 2, PATTERN_MAX + 2);
                end else begin
                    plen = $urandom_range(6);
                end
                repeat (plen) send_item(FUNC_APPEND, pick_pattern_byte());
                repeat ($urandom_range(1, 4)) send_name($urandom_range(3) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        live_pos = restarted_positions();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 30;
        snk_idle_pct = 71;
        test_corner_cases();
        test_pattern_overflow();
        test_output_backpressure();
        test_random_traffic(30, 71, 230);
        test_random_traffic(71, 30, 230);
        test_random_traffic(0, 0, 230);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("PASS glob_segment_matcher_core");
        end else begin
            $display("FAIL glob_segment_matcher_core");
        end
        $finish;
    end

endmodule
